[src/alt_pkg.sv]
// Package for the argument line tokenizer: beat types, decoder state and character codes.
// Depends on nothing; every other file in src imports it.
`timescale 1ns / 1ps

package alt_pkg;

  // Request kinds
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Result kinds
  localparam logic RES_APPEND = 1'b0;
  localparam logic RES_END    = 1'b1;

  // Quote modes (code three is never entered and is read as double quotes)
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam logic [7:0] CH_VT        = 8'h0B;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_NUL       = 8'h00;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_value;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_char;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] quote_mode;
    logic       backslash_pending;
    logic       argument_nonempty;
  } tok_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

[src/argument_line_tokenizer.sv]
// Top level of the argument line tokenizer: input register, decoder state, result registers.
// Depends on alt_pkg and alt_step.
`timescale 1ns / 1ps

// Shell-style argument splitter. Feed one character per req beat and finish each
// string with an end beat; res beats append a character to the current argument or
// mark its end, and last_of_run flags the final result of each request. The block
// takes one request per cycle while its results are taken as they come: a request
// is held in the input register, decoded against the quote and backslash state once
// the result register is free, and its results land in a two-entry result register.
// A request that yields two results holds the result register for two beats, which
// stalls input meanwhile; requests that yield none load nothing but still wait until
// the result register frees.
module argument_line_tokenizer
  import alt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic       hold_valid;
  req_t       hold_item;
  tok_state_t state;
  tok_state_t state_next;
  logic [1:0] count;
  res_t       res0;
  res_t       res1;
  logic       head_valid;
  logic       tail_valid;
  res_t       head;
  res_t       tail;
  logic       out_free;
  logic       advance;

  alt_step u_step (
    .state      (state),
    .item       (hold_item),
    .state_next (state_next),
    .count      (count),
    .res0       (res0),
    .res1       (res1)
  );

  // Result register frees when empty or its last beat leaves now
  assign out_free  = !head_valid || (res_ready && !tail_valid);
  assign advance   = hold_valid && out_free;
  assign req_ready = !hold_valid || out_free;
  assign res_valid = head_valid;
  assign res       = head;

  // Hold the accepted request beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      hold_item <= req;
    end
  end

  // Advance the tokenizer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{quote_mode: QM_NONE, backslash_pending: 1'b0, argument_nonempty: 1'b0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (advance) begin
      head_valid <= (count != 2'd0);
      tail_valid <= (count == 2'd2);
      head       <= res0;
      tail       <= res1;
    end else if (head_valid && res_ready) begin
      head_valid <= tail_valid;
      tail_valid <= 1'b0;
      head       <= tail;
    end
  end

endmodule

[src/alt_step.sv]
// Tokenizer step: from the current state and one request beat, work out up to two
// results and the next state. Pure combinational logic; uses alt_pkg.
`timescale 1ns / 1ps

module alt_step
  import alt_pkg::*;
(
  input  tok_state_t state,
  input  req_t       item,
  output tok_state_t state_next,
  output logic [1:0] count,
  output res_t       res0,
  output res_t       res1
);

  logic [7:0] c;
  logic [7:0] q;
  logic       k0;
  logic [7:0] c0;
  logic       k1;
  logic [7:0] c1;

  assign c = item.char_value;
  assign q = (state.quote_mode == QM_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

  // Decode one beat
  always_comb begin
    state_next = state;
    count      = 2'd0;
    k0         = RES_APPEND;
    c0         = CH_NUL;
    k1         = RES_APPEND;
    c1         = CH_NUL;
    if (item.req_type == REQ_END) begin
      // flush pending backslash, close argument, return to reset state
      if (state.backslash_pending) begin
        // the flushed backslash makes the argument non-empty, so it always ends
        c0    = CH_BACKSLASH;
        k1    = RES_END;
        count = 2'd2;
      end else if (state.argument_nonempty) begin
        k0    = RES_END;
        count = 2'd1;
      end
      state_next.quote_mode        = QM_NONE;
      state_next.backslash_pending = 1'b0;
      state_next.argument_nonempty = 1'b0;
    end else if (state.quote_mode != QM_NONE) begin
      // inside a quoted span
      if (state.backslash_pending) begin
        state_next.argument_nonempty = 1'b1;
        if (c == q) begin
          c0    = q;
          count = 2'd1;
          state_next.backslash_pending = 1'b0;
        end else if (c == CH_BACKSLASH) begin
          c0    = CH_BACKSLASH;
          count = 2'd1;
        end else begin
          c0    = CH_BACKSLASH;
          c1    = c;
          count = 2'd2;
          state_next.backslash_pending = 1'b0;
        end
      end else if (c == q) begin
        state_next.quote_mode = QM_NONE;
      end else if (c == CH_BACKSLASH) begin
        state_next.backslash_pending = 1'b1;
      end else begin
        c0    = c;
        count = 2'd1;
        state_next.argument_nonempty = 1'b1;
      end
    end else begin
      // outside quotes
      if (state.backslash_pending) begin
        state_next.backslash_pending = 1'b0;
        if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_SPACE || c == CH_BACKSLASH) begin
          c0    = c;
          count = 2'd1;
          state_next.argument_nonempty = 1'b1;
        end else begin
          c0    = CH_BACKSLASH;
          count = 2'd2;
          if (is_ws(c)) begin
            k1 = RES_END;
            state_next.argument_nonempty = 1'b0;
          end else begin
            c1 = c;
            state_next.argument_nonempty = 1'b1;
          end
        end
      end else if (is_ws(c)) begin
        if (state.argument_nonempty) begin
          k0    = RES_END;
          count = 2'd1;
        end
        state_next.argument_nonempty = 1'b0;
      end else if (c == CH_SQUOTE) begin
        state_next.quote_mode = QM_SINGLE;
      end else if (c == CH_DQUOTE) begin
        state_next.quote_mode = QM_DOUBLE;
      end else if (c == CH_BACKSLASH) begin
        state_next.backslash_pending = 1'b1;
      end else begin
        c0    = c;
        count = 2'd1;
        state_next.argument_nonempty = 1'b1;
      end
    end
  end

  // Mark the final result of the run
  assign res0 = '{result_kind: k0, out_char: c0, last_of_run: (count == 2'd1)};
  assign res1 = '{result_kind: k1, out_char: c1, last_of_run: 1'b1};

endmodule
